[hdl/nwbs_pkg.sv]
`default_nettype none

package nwbs_pkg;

    // Sizing of the scanner.
    localparam int MAX_PATTERN_BYTES = 8;
    localparam int OFFSET_BITS       = 32;

    // Fixed field widths.
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CARE_W     = 2 * MAX_PATTERN_BYTES;
    localparam int PATTERN_W  = BYTE_W * MAX_PATTERN_BYTES;
    localparam int MATCH_OFS_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // The window holds the bytes before the current one.
    localparam int WIN_BYTES = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
    localparam int IDX_W     = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNATURE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_CARE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    typedef logic [WIN_BYTES-1:0][BYTE_W-1:0] t_window;

    typedef struct packed {
        logic [PATTERN_W-1:0] signature;
        logic [CARE_W-1:0]    nibble_care;
        logic [LEN_W-1:0]     pattern_length;
    } t_cfg;

    typedef struct packed {
        logic                   found;
        logic [MATCH_OFS_W-1:0] offset;
    } t_match;

endpackage

`default_nettype wire

[hdl/nibble_wildcard_byte_scanner_top.sv]
`default_nettype none

// Channel   Direction  tdata                  tuser            tlast
// s_axis    in         [7:0] data_byte        -                last_byte
// m_axis    out        [31:0] match_offset    [0] match_found  buffer_end
// cfg       in         i_cfg_wdata to register i_cfg_index, written when i_cfg_we is high
//
// One word is accepted per cycle while the input is not stalled. A word is held in
// the input register while the window compare and offset subtract run, and its
// result is registered in the output register as the word leaves the input register.
// A word that yields no result never waits on the output side.
// The input stalls only when the input register holds a word with a result while
// the output register is full and not taken. Reset is synchronous, active low.
module nibble_wildcard_byte_scanner_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nwbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nwbs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [nwbs_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] data_byte
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [nwbs_pkg::MATCH_OFS_W-1:0]  m_axis_tdata,   // [31:0] match_offset
    output logic                              m_axis_tuser,   // [0] match_found
    output logic                              m_axis_tlast
);
    import nwbs_pkg::*;

    t_cfg                     r_cfg;
    logic                     r_s1_valid;
    logic [BYTE_W-1:0]        r_s1_byte;
    logic                     r_s1_last;
    t_window                  r_window;
    t_window                  n_window;
    logic [OFFSET_BITS-1:0]   r_bytes_seen;
    logic [OFFSET_BITS-1:0]   n_bytes_seen;
    logic                     r_out_valid;
    logic [MATCH_OFS_W-1:0]   r_out_offset;
    logic                     r_out_found;
    logic                     r_out_last;

    t_match                   match;
    logic                     produce;
    logic                     out_free;
    logic                     s1_fire;
    logic                     s_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIGNATURE:      r_cfg.signature      <= i_cfg_wdata[PATTERN_W-1:0];
                CFG_NIBBLE_CARE:    r_cfg.nibble_care    <= i_cfg_wdata[CARE_W-1:0];
                CFG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    nwbs_match u_match (
        .i_cfg        (r_cfg),
        .i_byte       (r_s1_byte),
        .i_window     (r_window),
        .i_bytes_seen (r_bytes_seen),
        .o_match      (match)
    );

    always_comb begin
        produce       = match.found || r_s1_last;
        out_free      = !r_out_valid || m_axis_tready;
        s1_fire       = r_s1_valid && (out_free || !produce);
        s_axis_tready = !r_s1_valid || s1_fire;
        s_accept      = s_axis_tvalid && s_axis_tready;
    end

    // The final word of a buffer clears the window and the counter.
    always_comb begin
        if (r_s1_last) begin
            n_window     = '0;
            n_bytes_seen = '0;
        end else begin
            n_window[0] = r_s1_byte;
            for (int k = 1; k < WIN_BYTES; k++) begin
                n_window[k] = r_window[k-1];
            end
            n_bytes_seen = (r_bytes_seen == COUNT_MAX) ? r_bytes_seen
                         : r_bytes_seen + OFFSET_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_window     <= '0;
            r_bytes_seen <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_window     <= n_window;
                r_bytes_seen <= n_bytes_seen;
            end
            if (s1_fire && produce) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_byte <= s_axis_tdata;
            r_s1_last <= s_axis_tlast;
        end
        if (s1_fire && produce) begin
            r_out_offset <= match.offset;
            r_out_found  <= match.found;
            r_out_last   <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_offset;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

[hdl/nwbs_match.sv]
`default_nettype none

// Compares the current byte and the window against the signature and
// works out the start offset of a match that ends at the current byte.
module nwbs_match (
    input  nwbs_pkg::t_cfg                      i_cfg,
    input  logic [nwbs_pkg::BYTE_W-1:0]         i_byte,
    input  nwbs_pkg::t_window                   i_window,
    input  logic [nwbs_pkg::OFFSET_BITS-1:0]    i_bytes_seen,
    output nwbs_pkg::t_match                    o_match
);
    import nwbs_pkg::*;

    logic [LEN_W-1:0]                         len_eff;
    logic [LEN_W-1:0]                         len_m1;
    logic [OFFSET_BITS-1:0]                   len_m1_ext;
    logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] cand;
    logic [MAX_PATTERN_BYTES-1:0]             byte_ok;
    logic [LEN_W-1:0]                         idx [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0]                        want [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0]                        mask [MAX_PATTERN_BYTES];
    logic                                     enough;
    logic                                     found;
    logic [OFFSET_BITS-1:0]                   offset;
    logic [MATCH_OFS_W+OFFSET_BITS-1:0]       offset_wide;

    always_comb begin
        len_eff = (i_cfg.pattern_length > LEN_W'(MAX_PATTERN_BYTES))
                ? LEN_W'(MAX_PATTERN_BYTES) : i_cfg.pattern_length;
        len_m1     = len_eff - LEN_W'(1);
        len_m1_ext = OFFSET_BITS'(len_m1);
    end

    // cand[0] is the current byte, cand[k] the byte k places back.
    always_comb begin
        cand[0] = i_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            cand[k] = i_window[k-1];
        end
    end

    // Signature byte j lines up with the byte len-1-j places back.
    always_comb begin
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            idx[j]  = len_m1 - LEN_W'(j);
            want[j] = i_cfg.signature[BYTE_W*j +: BYTE_W];
            mask[j] = {{4{i_cfg.nibble_care[2*j+1]}}, {4{i_cfg.nibble_care[2*j]}}};
            byte_ok[j] = (LEN_W'(j) >= len_eff)
                || (((cand[idx[j][IDX_W-1:0]] ^ want[j]) & mask[j]) == '0);
        end
    end

    always_comb begin
        enough      = (len_eff != '0) && (i_bytes_seen >= len_m1_ext);
        found       = enough && (&byte_ok);
        offset      = found ? (i_bytes_seen - len_m1_ext) : '0;
        offset_wide = {{MATCH_OFS_W{1'b0}}, offset};
        o_match.found  = found;
        o_match.offset = offset_wide[MATCH_OFS_W-1:0];
    end

endmodule

`default_nettype wire

[hdl/nwbs_checker.sv]
`default_nettype none

module nwbs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nwbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nwbs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [nwbs_pkg::BYTE_W-1:0]       s_axis_tdata,
    input  logic                              s_axis_tlast,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [nwbs_pkg::MATCH_OFS_W-1:0]  m_axis_tdata,
    input  logic                              m_axis_tuser,
    input  logic                              m_axis_tlast
);
    import nwbs_pkg::*;

    // A stalled result word keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // Every result word carries a match, a buffer end, or both.
    a_out_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
        else $error("result word without match or buffer end");

    // Without a match the offset reads as zero.
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0))
        else $error("offset nonzero on a word without a match");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

endmodule

bind nibble_wildcard_byte_scanner_top nwbs_checker u_nwbs_checker (.*);

`default_nettype wire

[sim/tb_nibble_wildcard_byte_scanner_top.sv]
`default_nettype none

module tb_nibble_wildcard_byte_scanner_top;

    import nwbs_pkg::*;

    localparam int RUN_LIMIT     = 250000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 10;
    localparam int PHASE_BYTES   = 60;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_scan_word;

    typedef struct {
        logic                   found;
        logic [MATCH_OFS_W-1:0] offset;
        logic                   at_end;
    } t_scan_hit;

    logic                     i_clk;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index   = CFG_SIGNATURE;
    logic [CFG_DATA_W-1:0]    i_cfg_wdata   = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [BYTE_W-1:0]        s_axis_tdata  = '0;   // [7:0] data_byte
    logic                     s_axis_tlast  = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [MATCH_OFS_W-1:0]   m_axis_tdata;         // [31:0] match_offset
    logic                     m_axis_tuser;         // [0] match_found
    logic                     m_axis_tlast;

    nibble_wildcard_byte_scanner_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow copy of the signature registers.
    logic [PATTERN_W-1:0]   sig_bytes = '0;
    logic [CARE_W-1:0]      sig_care  = '0;
    logic [LEN_W-1:0]       sig_len   = '0;

    // Shadow scan state: previous bytes of this buffer, most recent first.
    logic [BYTE_W-1:0]      recent [WIN_BYTES];
    logic [OFFSET_BITS-1:0] seen_cnt;

    t_scan_word  byte_feed [$];
    t_scan_hit   pending_hits [$];

    int          err_count     = 0;
    int          src_gap_max   = 0;
    int          sink_gap_max  = 0;
    int          src_wait      = 0;
    int          sink_wait     = 0;
    int          hold_req      = 0;
    int          hold_left     = 0;
    int unsigned cycle_cnt     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
        err_count++;
    endtask

    // Applies one accepted word to the shadow state and queues the result it causes.
    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
        int                 len;
        int                 j;
        int                 back;
        logic [BYTE_W-1:0]  v;
        logic [BYTE_W-1:0]  want;
        logic [BYTE_W-1:0]  care_mask;
        t_scan_hit          hit;
        len = (sig_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(sig_len);
        hit.found  = 1'b0;
        hit.offset = '0;
        hit.at_end = last;
        if (len != 0 && seen_cnt >= OFFSET_BITS'(len - 1)) begin
            hit.found = 1'b1;
            for (j = 0; j < len; j++) begin
                back = len - 1 - j;
                v = (back == 0) ? b : recent[back - 1];
                want = sig_bytes[8 * j +: 8];
                care_mask = {{4{sig_care[2 * j + 1]}}, {4{sig_care[2 * j]}}};
                if (((v ^ want) & care_mask) != '0)
                    hit.found = 1'b0;
            end
            if (hit.found)
                hit.offset = MATCH_OFS_W'(seen_cnt - OFFSET_BITS'(len - 1));
        end
        if (last) begin
            for (j = 0; j < WIN_BYTES; j++)
                recent[j] = '0;
            seen_cnt = '0;
        end else begin
            for (j = WIN_BYTES - 1; j > 0; j--)
                recent[j] = recent[j - 1];
            recent[0] = b;
            if (seen_cnt != COUNT_MAX)
                seen_cnt++;
        end
        if (hit.found || hit.at_end)
            pending_hits.insert(pending_hits.size(), hit);
    endtask

    // Driver: presents queued words with a random gap before each one.
    always @(posedge i_clk) begin
        t_scan_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                scan_byte(s_axis_tdata, s_axis_tlast);
                src_wait = $urandom_range(0, src_gap_max);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (byte_feed.size() != 0) begin
                    w = byte_feed.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= w.data;
                    s_axis_tlast  <= w.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_scan_hit e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_hits.size() == 0) begin
                    report_error($sformatf("unexpected result: found %0b offset %0d end %0b",
                                           m_axis_tuser, m_axis_tdata, m_axis_tlast));
                end else begin
                    e = pending_hits.pop_front();
                    if (m_axis_tuser !== e.found)
                        report_error($sformatf("match_found %0b, expected %0b",
                                               m_axis_tuser, e.found));
                    if (m_axis_tdata !== e.offset)
                        report_error($sformatf("match_offset %0d, expected %0d",
                                               m_axis_tdata, e.offset));
                    if (m_axis_tlast !== e.at_end)
                        report_error($sformatf("buffer_end %0b, expected %0b",
                                               m_axis_tlast, e.at_end));
                end
                sink_wait = $urandom_range(0, sink_gap_max);
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("ERROR: run did not finish within %0d cycles", RUN_LIMIT);
        $display("** nibble_wildcard_byte_scanner_top: FAILED **");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_SIGNATURE:      sig_bytes = val[PATTERN_W-1:0];
            CFG_NIBBLE_CARE:    sig_care  = val[CARE_W-1:0];
            CFG_PATTERN_LENGTH: sig_len   = val[LEN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [PATTERN_W-1:0] pat, input logic [CARE_W-1:0] care,
                             input logic [LEN_W-1:0] len);
        write_reg(CFG_SIGNATURE, CFG_DATA_W'(pat));
        write_reg(CFG_NIBBLE_CARE, CFG_DATA_W'(care));
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
    endtask

    task automatic push_word(input logic [BYTE_W-1:0] data, input logic last);
        t_scan_word w;
        w.data = data;
        w.last = last;
        byte_feed.insert(byte_feed.size(), w);
    endtask

    // Holds the sender until every word is in and every result is out, then lets
    // words that cause no result clear the pipeline.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_feed.size() != 0 || s_axis_tvalid || pending_hits.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly copies of the signature with random wildcard nibbles, now and then
    // cut short or with one bit flipped, mixed with random filler bytes.
    task automatic queue_buffer(input int n_bytes);
        int                eff;
        int                pos;
        int                cut;
        int                j;
        logic [BYTE_W-1:0] mask;
        logic [BYTE_W-1:0] v;
        eff = (sig_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(sig_len);
        pos = 0;
        while (pos < n_bytes) begin
            if (eff != 0 && $urandom_range(0, 2) == 0) begin
                cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff) : eff;
                for (j = 0; j < cut && pos < n_bytes; j++) begin
                    mask = {{4{sig_care[2 * j + 1]}}, {4{sig_care[2 * j]}}};
                    v = (sig_bytes[8 * j +: 8] & mask) | (BYTE_W'($urandom) & ~mask);
                    if ($urandom_range(0, 15) == 0)
                        v = v ^ (BYTE_W'(1) << $urandom_range(0, BYTE_W - 1));
                    push_word(v, pos == n_bytes - 1);
                    pos++;
                end
            end else begin
                push_word(BYTE_W'($urandom), pos == n_bytes - 1);
                pos++;
            end
        end
    endtask

    initial begin
        int                   p;
        int                   fed;
        int                   n;
        logic [PATTERN_W-1:0] pat;
        logic [CARE_W-1:0]    care;
        logic [LEN_W-1:0]     len;

        for (p = 0; p < WIN_BYTES; p++)
            recent[p] = '0;
        seen_cnt = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Signature 5A ?? F?: full care on byte 0, wildcard byte 1, high nibble of byte 2.
        src_gap_max  = 3;
        sink_gap_max = 3;
        configure(64'h0000_0000_00F3_005A, 16'h0023, 4'd3);
        // Overlapping matches at offsets 0, 3 and 4, then a buffer end with no match.
        push_word(8'h5A, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'hF0, 1'b0);
        push_word(8'h5A, 1'b0);
        push_word(8'h5A, 1'b0);
        push_word(8'hF5, 1'b0);
        push_word(8'hF0, 1'b0);
        push_word(8'h00, 1'b1);
        // Buffer shorter than the signature.
        push_word(8'h5A, 1'b0);
        push_word(8'hF0, 1'b1);
        // The leftover 5A 00 must not combine with the next buffer's first byte.
        push_word(8'h5A, 1'b0);
        push_word(8'h00, 1'b1);
        push_word(8'hF2, 1'b0);
        push_word(8'h00, 1'b1);
        // Match that ends on the final byte of the buffer.
        push_word(8'h5A, 1'b0);
        push_word(8'h11, 1'b0);
        push_word(8'hFF, 1'b1);
        wait_drained();

        // Length above the maximum acts as eight all-wildcard bytes.
        configure('1, '0, 4'd15);
        for (p = 0; p < MAX_PATTERN_BYTES; p++)
            push_word((p % 2 == 0) ? 8'h00 : 8'hFF, p == MAX_PATTERN_BYTES - 1);
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin pat = '1; care = '1; len = 4'd8; end
                1: begin pat = '0; care = CARE_W'($urandom); len = 4'd0; end
                2: begin pat = {$urandom, $urandom}; care = CARE_W'($urandom); len = 4'd15; end
                3: begin pat = {$urandom, $urandom}; care = '0; len = 4'd1; end
                9: begin
                    pat  = {$urandom, $urandom};
                    care = CARE_W'($urandom);
                    len  = LEN_W'($urandom_range(9, 15));
                end
                default: begin
                    pat  = {$urandom, $urandom};
                    care = CARE_W'($urandom);
                    len  = LEN_W'($urandom_range(1, MAX_PATTERN_BYTES));
                end
            endcase
            configure(pat, care, len);
            src_gap_max  = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 4);
            sink_gap_max = ((p / 2) % 3 == 0) ? 15 : (((p / 2) % 3 == 1) ? 0 : 4);
            fed = 0;
            while (fed < PHASE_BYTES) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 24);
                queue_buffer(n);
                fed += n;
            end
            wait_drained();
        end

        // Every byte matches a one-byte wildcard signature; the receiver stalls for a
        // long stretch while the sender keeps offering, so the input has to back up.
        configure({$urandom, $urandom}, '0, 4'd1);
        src_gap_max  = 0;
        sink_gap_max = 2;
        @(negedge i_clk);
        hold_req = 300;
        queue_buffer(30);
        queue_buffer(30);
        wait_drained();

        if (err_count == 0)
            $display("** nibble_wildcard_byte_scanner_top: PASSED **");
        else
            $display("** nibble_wildcard_byte_scanner_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hdl/nwbs_pkg.sv
hdl/nwbs_match.sv
hdl/nibble_wildcard_byte_scanner_top.sv
hdl/nwbs_checker.sv
sim/tb_nibble_wildcard_byte_scanner_top.sv
